@@ hdl/cpd_pkg.sv @@
// Shared constants and types for the camera packet deframer.
package cpd_pkg;

    // Header bytes that open each of the three sections of a packet.
    localparam logic [7:0] HDR_FIRST  = 8'd201;
    localparam logic [7:0] HDR_SECOND = 8'd202;
    localparam logic [7:0] HDR_THIRD  = 8'd203;

    // Offset taken off every Y byte.
    localparam logic [8:0] Y_BIAS = 9'd100;

    // A hidden object reports x of zero and y of minus one hundred.
    localparam logic [8:0] HIDDEN_Y = 9'h19C;

    // Field widths.
    localparam int XW = 8;
    localparam int YW = 9;
    localparam int CW = 32;

    // Result word packed onto the master tdata bus, padded to whole bytes.
    localparam int RESULT_W = 3 * XW + 3 * YW + 3 + 2 * CW;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // One decoded packet; the last field sits in the lowest bits when packed.
    typedef struct packed {
        logic [CW-1:0]        resync_count;
        logic [CW-1:0]        packet_count;
        logic                 blue_seen;
        logic                 yellow_seen;
        logic                 ball_seen;
        logic signed [YW-1:0] blue_y;
        logic [XW-1:0]        blue_x;
        logic signed [YW-1:0] yellow_y;
        logic [XW-1:0]        yellow_x;
        logic signed [YW-1:0] ball_y;
        logic [XW-1:0]        ball_x;
    } result_t;

    // Y byte with the bias removed, in 9-bit two's complement.
    function automatic logic [YW-1:0] y_of(input logic [XW-1:0] b);
        y_of = {1'b0, b} - Y_BIAS;
    endfunction

    // Visibility flag: clear only for the hidden-object code.
    function automatic logic seen(input logic [XW-1:0] x, input logic [YW-1:0] y);
        seen = !((x == '0) && (y == HIDDEN_Y));
    endfunction

endpackage

@@ hdl/camera_packet_deframer.sv @@
// Camera packet deframer: frames 9-byte coordinate packets from a byte stream.
//
//  Channel   Direction  Word contents
//  s_axis    in         rx_byte, one received serial byte
//  m_axis    out        ball/yellow/blue coordinates, seen flags, both counters
//
// One byte is taken every clock while the input is not held back. Each byte is
// held in an input register, then the phase decoder updates the parse state and,
// on the last byte of a packet, loads the result register, from which the word
// is presented. aresetn is synchronous and clears the phase, both counters and
// both valid flags. A stalled result only holds back the input when the byte in
// the input register is the last byte of a packet.
module camera_packet_deframer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [7:0] ball_x, [16:8] ball_y, [24:17] yellow_x, [33:25] yellow_y,
    // [41:34] blue_x, [50:42] blue_y, [51] ball_seen, [52] yellow_seen,
    // [53] blue_seen, [85:54] packet_count, [117:86] resync_count, rest zero
    output logic [cpd_pkg::TDATA_W-1:0] m_axis_tdata
);

    // Parse phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_BALL_X   = 4'd1;
    localparam logic [3:0] PH_BALL_Y   = 4'd2;
    localparam logic [3:0] PH_HDR_2    = 4'd3;
    localparam logic [3:0] PH_YEL_X    = 4'd4;
    localparam logic [3:0] PH_YEL_Y    = 4'd5;
    localparam logic [3:0] PH_HDR_3    = 4'd6;
    localparam logic [3:0] PH_BLUE_X   = 4'd7;
    localparam logic [3:0] PH_BLUE_Y   = 4'd8;

    logic                       in_valid_reg;
    logic [cpd_pkg::XW-1:0]     in_byte_reg;
    logic [3:0]                 phase_reg, phase_next;
    logic [cpd_pkg::XW-1:0]     ball_x_reg, yel_x_reg, blue_x_reg;
    logic [cpd_pkg::YW-1:0]     ball_y_reg, yel_y_reg;
    logic [cpd_pkg::CW-1:0]     decoded_reg, decoded_next;
    logic [cpd_pkg::CW-1:0]     resync_reg, resync_next;
    logic                       out_valid_reg;
    cpd_pkg::result_t           out_reg, out_next;
    logic                       produces;
    logic                       out_free;
    logic                       advance;
    logic [cpd_pkg::YW-1:0]     cur_y;

    // Handshake: a byte leaves the input register unless it would need a full result slot.
    assign produces      = (phase_reg == PH_BLUE_Y);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!produces || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign cur_y = cpd_pkg::y_of(in_byte_reg);

    // Phase decoder and counters.
    always_comb begin
        phase_next   = phase_reg;
        resync_next  = resync_reg;
        decoded_next = decoded_reg;
        case (phase_reg)
            PH_BALL_X: phase_next = PH_BALL_Y;
            PH_BALL_Y: phase_next = PH_HDR_2;
            PH_HDR_2: begin
                if (in_byte_reg == cpd_pkg::HDR_SECOND) begin
                    phase_next = PH_YEL_X;
                end else begin
                    resync_next = resync_reg + 1'b1;
                    phase_next  = (in_byte_reg == cpd_pkg::HDR_FIRST) ? PH_BALL_X : PH_IDLE;
                end
            end
            PH_YEL_X: phase_next = PH_YEL_Y;
            PH_YEL_Y: phase_next = PH_HDR_3;
            PH_HDR_3: begin
                if (in_byte_reg == cpd_pkg::HDR_THIRD) begin
                    phase_next = PH_BLUE_X;
                end else begin
                    resync_next = resync_reg + 1'b1;
                    phase_next  = (in_byte_reg == cpd_pkg::HDR_FIRST) ? PH_BALL_X : PH_IDLE;
                end
            end
            PH_BLUE_X: phase_next = PH_BLUE_Y;
            PH_BLUE_Y: begin
                decoded_next = decoded_reg + 1'b1;
                phase_next   = PH_IDLE;
            end
            default: begin
                phase_next = (in_byte_reg == cpd_pkg::HDR_FIRST) ? PH_BALL_X : PH_IDLE;
            end
        endcase
    end

    // Result word assembled from the captured bytes and the final Y byte.
    always_comb begin
        out_next.ball_x       = ball_x_reg;
        out_next.ball_y       = ball_y_reg;
        out_next.yellow_x     = yel_x_reg;
        out_next.yellow_y     = yel_y_reg;
        out_next.blue_x       = blue_x_reg;
        out_next.blue_y       = cur_y;
        out_next.ball_seen    = cpd_pkg::seen(ball_x_reg, ball_y_reg);
        out_next.yellow_seen  = cpd_pkg::seen(yel_x_reg, yel_y_reg);
        out_next.blue_seen    = cpd_pkg::seen(blue_x_reg, cur_y);
        out_next.packet_count = decoded_next;
        out_next.resync_count = resync_reg;
    end

    // Parse state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            decoded_reg <= '0;
            resync_reg  <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            decoded_reg <= decoded_next;
            resync_reg  <= resync_next;
        end
    end

    // Coordinate capture; no reset, each is written before any packet uses it.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (phase_reg == PH_BALL_X) ball_x_reg <= in_byte_reg;
            if (phase_reg == PH_BALL_Y) ball_y_reg <= cur_y;
            if (phase_reg == PH_YEL_X)  yel_x_reg  <= in_byte_reg;
            if (phase_reg == PH_YEL_Y)  yel_y_reg  <= cur_y;
            if (phase_reg == PH_BLUE_X) blue_x_reg <= in_byte_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && produces) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && produces) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(cpd_pkg::TDATA_W - cpd_pkg::RESULT_W){1'b0}}, out_reg};

    // The phase never leaves the range of defined codes.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_BLUE_Y)
        else $error("parse phase out of range");

    // Finishing a packet always loads a result word for the output.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && produces |=> m_axis_tvalid && (decoded_reg == out_reg.packet_count))
        else $error("finished packet not presented");

    // The resync counter only moves on a consumed byte in a header phase.
    a_resync_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (resync_reg != $past(resync_reg)) |->
            $past(advance) && ($past(phase_reg) == PH_HDR_2 || $past(phase_reg) == PH_HDR_3))
        else $error("resync counter moved outside a header phase");

    // The packet counter only moves when a result is produced.
    a_decoded_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (decoded_reg != $past(decoded_reg)) |-> m_axis_tvalid)
        else $error("packet counter moved without a result");

endmodule

@@ tb/camera_packet_deframer_check.sv @@
// Checker for the camera packet deframer: predicts every packet word and compares it.
module camera_packet_deframer_check
    import cpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,
    output int                 fail_count,
    output int                 packets_pending
);

    // Where the parser stands within a packet.
    typedef enum logic [3:0] {
        WAIT_HDR, BALL_X, BALL_Y, WAIT_HDR2, YEL_X, YEL_Y, WAIT_HDR3, BLUE_X, BLUE_Y
    } phase_e;

    phase_e         phase;
    logic [XW-1:0]  ball_x_r, yel_x_r, blue_x_r;
    logic [YW-1:0]  ball_y_r, yel_y_r;
    logic [CW-1:0]  decoded, resyncs;
    result_t        expected_words[$];
    int             errors = 0;

    assign fail_count      = errors;
    assign packets_pending = expected_words.size();

    // Y bytes carry a fixed offset of one hundred.
    function automatic logic [YW-1:0] remove_bias(input logic [7:0] b);
        return {1'b0, b} - Y_BIAS;
    endfunction

    // An object is hidden only when it reports x of zero and y of minus one hundred.
    function automatic logic visible(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return !(x == '0 && y == HIDDEN_Y);
    endfunction

    // A wrong second or third header counts as a resync; a first header restarts at once.
    task automatic header_missed(input logic [7:0] b);
        resyncs = resyncs + 1'b1;
        phase   = (b == HDR_FIRST) ? BALL_X : WAIT_HDR;
    endtask

    // Advances the parser by one byte and queues the word that the last byte releases.
    task automatic parse_byte(input logic [7:0] b);
        result_t w;
        case (phase)
            BALL_X: begin
                ball_x_r = b;
                phase    = BALL_Y;
            end
            BALL_Y: begin
                ball_y_r = remove_bias(b);
                phase    = WAIT_HDR2;
            end
            WAIT_HDR2: begin
                if (b != HDR_SECOND) header_missed(b);
                else phase = YEL_X;
            end
            YEL_X: begin
                yel_x_r = b;
                phase   = YEL_Y;
            end
            YEL_Y: begin
                yel_y_r = remove_bias(b);
                phase   = WAIT_HDR3;
            end
            WAIT_HDR3: begin
                if (b != HDR_THIRD) header_missed(b);
                else phase = BLUE_X;
            end
            BLUE_X: begin
                blue_x_r = b;
                phase    = BLUE_Y;
            end
            BLUE_Y: begin
                decoded        = decoded + 1'b1;
                w.ball_x       = ball_x_r;
                w.ball_y       = ball_y_r;
                w.yellow_x     = yel_x_r;
                w.yellow_y     = yel_y_r;
                w.blue_x       = blue_x_r;
                w.blue_y       = remove_bias(b);
                w.ball_seen    = visible(ball_x_r, ball_y_r);
                w.yellow_seen  = visible(yel_x_r, yel_y_r);
                w.blue_seen    = visible(blue_x_r, w.blue_y);
                w.packet_count = decoded;
                w.resync_count = resyncs;
                expected_words.push_back(w);
                phase = WAIT_HDR;
            end
            default: phase = (b == HDR_FIRST) ? BALL_X : WAIT_HDR;
        endcase
    endtask

    task automatic check_field(input string name, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // The output side is looked at first, so a byte taken on the same edge
    // can never be matched against the word leaving at that edge.
    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            phase   = WAIT_HDR;
            decoded = '0;
            resyncs = '0;
            expected_words.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[RESULT_W-1:0]);
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected packet word, expected none, got %0h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("ball_x", want.ball_x, got.ball_x);
                    check_field("ball_y", want.ball_y, got.ball_y);
                    check_field("yellow_x", want.yellow_x, got.yellow_x);
                    check_field("yellow_y", want.yellow_y, got.yellow_y);
                    check_field("blue_x", want.blue_x, got.blue_x);
                    check_field("blue_y", want.blue_y, got.blue_y);
                    check_field("ball_seen", want.ball_seen, got.ball_seen);
                    check_field("yellow_seen", want.yellow_seen, got.yellow_seen);
                    check_field("blue_seen", want.blue_seen, got.blue_seen);
                    check_field("packet_count", want.packet_count, got.packet_count);
                    check_field("resync_count", want.resync_count, got.resync_count);
                    check_field("padding", '0, m_axis_tdata[TDATA_W-1:RESULT_W]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
        end
    end

endmodule

@@ tb/camera_packet_deframer_tb.sv @@
// Top-level testbench for the camera packet deframer: clock, reset, stimulus and verdict.
module camera_packet_deframer_tb;
    import cpd_pkg::*;

    localparam int BYTE_TARGET  = 850;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic               aclk;
    logic               aresetn;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    int         fail_count;
    int         packets_pending;
    int         cycle_count = 0;
    int         frame_bytes = 0;
    bit         hold_req = 0;
    logic [7:0] frame_q[$];

    camera_packet_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    camera_packet_deframer_check packet_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .packets_pending (packets_pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinate bytes lean towards the edges, the zero point of Y and header values.
    function automatic logic [7:0] coord_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(Y_BIAS);
            3: return 8'($urandom_range(HDR_FIRST, HDR_THIRD));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One x and y pair, sometimes the hidden-object code.
    task automatic add_object();
        if ($urandom_range(0, 5) == 0) begin
            frame_q.push_back(8'd0);
            frame_q.push_back(8'd0);
        end else begin
            frame_q.push_back(coord_byte());
            frame_q.push_back(coord_byte());
        end
    endtask

    // Everything of a packet after the ball x and y pair's leading header.
    task automatic add_tail();
        add_object();
        frame_q.push_back(HDR_SECOND);
        add_object();
        frame_q.push_back(HDR_THIRD);
        add_object();
    endtask

    // A wrong header byte, half of the time a first header that restarts the packet.
    task automatic add_bad_header(input logic [7:0] good);
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) begin
            frame_q.push_back(HDR_FIRST);
            add_tail();
        end else begin
            do b = 8'($urandom_range(0, 255)); while (b == good || b == HDR_FIRST);
            frame_q.push_back(b);
        end
    endtask

    // Offers one byte and waits until the block takes it.
    task automatic send_byte(input logic [7:0] b, input bit calm);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Every byte sent counts towards the target, noise and directed bytes too.
    task automatic send_frame(input bit calm);
        frame_bytes += frame_q.size();
        foreach (frame_q[i]) send_byte(frame_q[i], calm);
        frame_q.delete();
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int quiet_left;
        int pause;
        quiet_left    = 0;
        m_axis_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 0;
            end else if (quiet_left > 0) begin
                quiet_left--;
                m_axis_tready = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                quiet_left    = $urandom_range(20, 80);
                m_axis_tready = 1'b1;
            end else begin
                pause = idle_len();
                if (pause == 0) begin
                    m_axis_tready = 1'b1;
                end else begin
                    m_axis_tready = 1'b0;
                    repeat (pause - 1) @(negedge aclk);
                end
            end
        end
    end

    // Stimulus: directed cases, a burst against a held receiver, then random traffic.
    initial begin
        int r;
        bit calm;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        aresetn       = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Noise before a packet, a packet of hidden objects, a packet of extremes
        // with header values as data, a wrong third header that restarts, and a
        // wrong second header that drops back to waiting.
        frame_q = '{8'd0, 8'd255,
                    HDR_FIRST, 8'd0, 8'd0, HDR_SECOND, 8'd0, 8'd0, HDR_THIRD, 8'd0, 8'd0,
                    HDR_FIRST, 8'd255, 8'd255, HDR_SECOND, HDR_FIRST, HDR_THIRD,
                    HDR_THIRD, HDR_SECOND, 8'(Y_BIAS),
                    HDR_FIRST, 8'd1, 8'd2, HDR_SECOND, 8'd3, 8'd4, HDR_FIRST,
                    8'd5, 8'd6, 8'd7};
        send_frame(1'b0);

        // Back-to-back packets while the receiver holds off, so the block fills up.
        hold_req = 1;
        repeat (12) begin
            frame_q.push_back(HDR_FIRST);
            add_tail();
            send_frame(1'b1);
        end

        while (frame_bytes < BYTE_TARGET) begin
            r    = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            if (r < 75) begin
                frame_q.push_back(HDR_FIRST);
                add_tail();
            end else if (r < 85) begin
                frame_q.push_back(HDR_FIRST);
                add_object();
                add_bad_header(HDR_SECOND);
            end else if (r < 93) begin
                frame_q.push_back(HDR_FIRST);
                add_object();
                frame_q.push_back(HDR_SECOND);
                add_object();
                add_bad_header(HDR_THIRD);
            end else begin
                repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            send_frame(calm);
        end
        s_axis_tvalid = 1'b0;

        wait (packets_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
